@@ hdl/aifp_pkg.sv @@
// types and constants shared by the integer field parser
// no dependencies; used by every module of the block except aifp_queue
`default_nettype none

package aifp_pkg;

    localparam int FIELD_W = 32;

    // command codes
    localparam logic [1:0] CMD_TEXT    = 2'd0;
    localparam logic [1:0] CMD_END     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // status codes
    localparam logic [1:0] ST_FIELD    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_END      = 2'd2;

    // base_mode codes, anything else is decimal
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_BASE_MODE  = 2'd0;
    localparam logic [1:0] REG_MAX_DIGITS = 2'd1;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [1:0]         status;
        logic               last_result;
    } t_out_item;

    typedef struct packed {
        logic [1:0] base_mode;
        logic [7:0] max_digits;
    } t_cfg;

    // classified byte as queued between front and back
    typedef struct packed {
        logic [1:0] command;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       dig_ok;
        logic [3:0] dig;
    } t_class;

    // back end handshake with the two queues
    typedef struct packed {
        logic pop;
        logic push;
        logic spill;
    } t_back_ctl;

endpackage

`default_nettype wire

@@ hdl/aifp_queue.sv @@
// small register queue used on both sides of the parser back end
// no package dependencies
`default_nettype none

module aifp_queue #(
    parameter int WIDTH      = 16,
    parameter int DEPTH_LOG2 = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr_ptr;
    logic [DEPTH_LOG2-1:0] r_rd_ptr;
    logic [DEPTH_LOG2:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (DEPTH_LOG2+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/aifp_front.sv @@
// front end: classifies each incoming byte for the configured base
// depends on aifp_pkg
`default_nettype none

module aifp_front (
    input  wire aifp_pkg::t_cfg     i_cfg,
    input  wire aifp_pkg::t_in_item i_item,
    output aifp_pkg::t_class        o_class
);

    logic       is_hex;
    logic       is_oct;
    logic       is_dec;
    logic [7:0] b;
    logic [7:0] num_dec;
    logic [7:0] num_lo;
    logic [7:0] num_up;

    assign b       = i_item.text_byte;
    assign is_hex  = (i_cfg.base_mode == aifp_pkg::BASE_HEX);
    assign is_oct  = (i_cfg.base_mode == aifp_pkg::BASE_OCT);
    assign is_dec  = !is_hex && !is_oct;
    assign num_dec = b - aifp_pkg::CH_0;
    assign num_lo  = (b - aifp_pkg::CH_A_LO) + 8'd10;
    assign num_up  = (b - aifp_pkg::CH_A_UP) + 8'd10;

    always_comb begin
        o_class.command  = i_item.command;
        o_class.is_ws    = (b == aifp_pkg::CH_SPACE)
                           || (b >= aifp_pkg::CH_TAB && b <= aifp_pkg::CH_CR);
        o_class.is_sign  = is_dec && (b == aifp_pkg::CH_MINUS || b == aifp_pkg::CH_PLUS);
        o_class.is_minus = (b == aifp_pkg::CH_MINUS);
        o_class.is_zero  = is_hex && (b == aifp_pkg::CH_0);
        o_class.is_x     = (b == aifp_pkg::CH_X_LO) || (b == aifp_pkg::CH_X_UP);
        o_class.dig_ok   = 1'b0;
        o_class.dig      = '0;
        if (b >= aifp_pkg::CH_0 && b <= aifp_pkg::CH_9) begin
            // 8 and 9 are not octal digits
            o_class.dig    = num_dec[3:0];
            o_class.dig_ok = !is_oct || !num_dec[3];
        end else if (is_hex && b >= aifp_pkg::CH_A_LO && b <= aifp_pkg::CH_F_LO) begin
            o_class.dig    = num_lo[3:0];
            o_class.dig_ok = 1'b1;
        end else if (is_hex && b >= aifp_pkg::CH_A_UP && b <= aifp_pkg::CH_F_UP) begin
            o_class.dig    = num_up[3:0];
            o_class.dig_ok = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/aifp_back.sv @@
// back end: field state machine, digit accumulation and result generation
// depends on aifp_pkg; fed from the classified-byte queue
`default_nettype none

module aifp_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire aifp_pkg::t_cfg     i_cfg,
    input  wire logic               i_item_valid,
    input  wire aifp_pkg::t_class   i_item,
    input  wire logic               i_out_full,
    output aifp_pkg::t_back_ctl     o_ctl,
    output aifp_pkg::t_out_item     o_result
);

    localparam int FW = aifp_pkg::FIELD_W;
    localparam int VB = VALUE_BITS;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    function automatic aifp_pkg::t_out_item mk_res(input logic [FW-1:0] v,
                                                   input logic [1:0] st);
        aifp_pkg::t_out_item r;
        r.field_value = v;
        r.status      = st;
        r.last_result = 1'b0;
        return r;
    endfunction

    t_phase              r_phase, n_phase;
    logic [VB-1:0]       r_acc, n_acc;
    logic [7:0]          r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic                r_halt, n_halt;
    logic                r_spill_v;
    aifp_pkg::t_out_item r_spill;

    logic [VB-1:0] dz;
    logic [VB-1:0] dig_acc;
    logic [VB-1:0] neg_dig;
    logic [VB-1:0] neg_cur;
    logic [7:0]    cnt_inc;
    logic          limit_inc;
    logic          max_one;
    logic          max_two;

    // outcome of a byte that opens a field from a cleared state
    t_phase              st_phase;
    logic [VB-1:0]       st_acc;
    logic [7:0]          st_cnt;
    logic                st_neg;
    logic                st_halt;
    logic                st_emit;
    aifp_pkg::t_out_item st_res;

    logic                e0_v, e1_v;
    aifp_pkg::t_out_item e0, e1;
    logic                take;

    assign dz      = VB'(i_item.dig);
    assign cnt_inc = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
    assign max_one = (i_cfg.max_digits == 8'd1);
    assign max_two = (i_cfg.max_digits == 8'd2);
    assign limit_inc = (i_cfg.max_digits != 8'd0) && (cnt_inc >= i_cfg.max_digits);

    // multiply by the base as shifts and adds
    always_comb begin
        if (i_cfg.base_mode == aifp_pkg::BASE_HEX) begin
            dig_acc = (r_acc << 4) + dz;
        end else if (i_cfg.base_mode == aifp_pkg::BASE_OCT) begin
            dig_acc = (r_acc << 3) + dz;
        end else begin
            dig_acc = (r_acc << 3) + (r_acc << 1) + dz;
        end
    end

    assign neg_dig = r_neg ? (~dig_acc) + VB'(1) : dig_acc;
    assign neg_cur = r_neg ? (~r_acc) + VB'(1) : r_acc;

    always_comb begin
        st_phase = PH_SKIP;
        st_acc   = '0;
        st_cnt   = '0;
        st_neg   = 1'b0;
        st_halt  = 1'b0;
        st_emit  = 1'b0;
        st_res   = mk_res('0, aifp_pkg::ST_FIELD);
        if (!i_item.is_ws) begin
            if (i_item.is_sign) begin
                st_neg   = i_item.is_minus;
                st_phase = PH_SIGN;
            end else if (i_item.is_zero) begin
                st_phase = PH_ZERO;
            end else if (i_item.dig_ok) begin
                if (max_one) begin
                    st_emit = 1'b1;
                    st_res  = mk_res(FW'(dz), aifp_pkg::ST_FIELD);
                end else begin
                    st_acc   = dz;
                    st_cnt   = 8'd1;
                    st_phase = PH_DIGITS;
                end
            end else begin
                st_emit = 1'b1;
                st_res  = mk_res('0, aifp_pkg::ST_MISMATCH);
                st_halt = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_halt  = r_halt;
        e0_v    = 1'b0;
        e1_v    = 1'b0;
        e0      = mk_res('0, aifp_pkg::ST_FIELD);
        e1      = mk_res('0, aifp_pkg::ST_FIELD);
        if (i_item.command == aifp_pkg::CMD_RESTART) begin
            n_phase = PH_SKIP;
            n_acc   = '0;
            n_cnt   = '0;
            n_neg   = 1'b0;
            n_halt  = 1'b0;
        end else if (i_item.command == aifp_pkg::CMD_END && !r_halt) begin
            if (r_phase == PH_DIGITS || r_phase == PH_ZERO) begin
                e0_v = 1'b1;
                e0   = mk_res(FW'(neg_cur), aifp_pkg::ST_FIELD);
                e1_v = 1'b1;
                e1   = mk_res('0, aifp_pkg::ST_END);
            end else begin
                e0_v = 1'b1;
                e0   = mk_res('0, aifp_pkg::ST_END);
            end
            n_phase = PH_SKIP;
            n_acc   = '0;
            n_cnt   = '0;
            n_neg   = 1'b0;
            n_halt  = 1'b1;
        end else if (i_item.command == aifp_pkg::CMD_TEXT && !r_halt) begin
            unique case (r_phase)
                PH_SIGN, PH_PREFIX, PH_DIGITS: begin
                    if (i_item.dig_ok) begin
                        n_acc   = dig_acc;
                        n_cnt   = cnt_inc;
                        n_phase = PH_DIGITS;
                        if (limit_inc) begin
                            e0_v    = 1'b1;
                            e0      = mk_res(FW'(neg_dig), aifp_pkg::ST_FIELD);
                            n_phase = PH_SKIP;
                            n_acc   = '0;
                            n_cnt   = '0;
                            n_neg   = 1'b0;
                        end
                    end else if (r_phase == PH_DIGITS) begin
                        // field ends here, the byte starts the next one
                        e0_v    = 1'b1;
                        e0      = mk_res(FW'(neg_cur), aifp_pkg::ST_FIELD);
                        e1_v    = st_emit;
                        e1      = st_res;
                        n_phase = st_phase;
                        n_acc   = st_acc;
                        n_cnt   = st_cnt;
                        n_neg   = st_neg;
                        n_halt  = st_halt;
                    end else begin
                        e0_v    = 1'b1;
                        e0      = mk_res('0, aifp_pkg::ST_MISMATCH);
                        n_phase = PH_SKIP;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_neg   = 1'b0;
                        n_halt  = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_item.is_x) begin
                        n_phase = PH_PREFIX;
                    end else if (!max_one && i_item.dig_ok) begin
                        // leading zero then a digit: two digits taken
                        if (max_two) begin
                            e0_v    = 1'b1;
                            e0      = mk_res(FW'(dz), aifp_pkg::ST_FIELD);
                            n_phase = PH_SKIP;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_phase = PH_DIGITS;
                            n_acc   = dz;
                            n_cnt   = 8'd2;
                        end
                        n_neg = 1'b0;
                    end else begin
                        // lone zero is a field, byte reprocessed
                        e0_v    = 1'b1;
                        e0      = mk_res('0, aifp_pkg::ST_FIELD);
                        e1_v    = st_emit;
                        e1      = st_res;
                        n_phase = st_phase;
                        n_acc   = st_acc;
                        n_cnt   = st_cnt;
                        n_neg   = st_neg;
                        n_halt  = st_halt;
                    end
                end
                default: begin
                    e0_v    = st_emit;
                    e0      = st_res;
                    n_phase = st_phase;
                    n_acc   = st_acc;
                    n_cnt   = st_cnt;
                    n_neg   = st_neg;
                    n_halt  = st_halt;
                end
            endcase
        end
        if (e1_v) begin
            e1.last_result = 1'b1;
        end else begin
            e0.last_result = 1'b1;
        end
    end

    assign take = i_item_valid && !r_spill_v && !i_out_full;

    always_comb begin
        o_ctl.pop   = take;
        o_ctl.spill = r_spill_v;
        if (r_spill_v) begin
            o_ctl.push = !i_out_full;
            o_result   = r_spill;
        end else begin
            o_ctl.push = take && e0_v;
            o_result   = e0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_neg     <= 1'b0;
            r_halt    <= 1'b0;
            r_spill_v <= 1'b0;
        end else if (r_spill_v) begin
            if (!i_out_full) begin
                r_spill_v <= 1'b0;
            end
        end else if (take) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_neg     <= n_neg;
            r_halt    <= n_halt;
            r_spill_v <= e1_v;
            r_spill   <= e1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ascii_integer_field_parser_core.sv @@
// top level of the ascii integer field parser: config registers and queues
// depends on aifp_pkg, aifp_front, aifp_queue, aifp_back
//
//   port group       dir   handshake                     payload
//   item request     in    i_item_valid / o_item_ready   i_item   (t_in_item)
//   result request   out   o_result_valid / i_result_ready o_result (t_out_item)
//   config write     in    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one item per cycle in while the input queue has room; the back end writes one
// result per cycle while the output queue has room, so an item with two results
// holds the back end until its second result is written from the spill register
// a four-entry queue on each side of the back end absorbs output stalls
// synchronous active-low reset clears config, queues and field state
`default_nettype none

module ascii_integer_field_parser_core #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_item_valid,
    output logic                     o_item_ready,
    input  wire aifp_pkg::t_in_item  i_item,
    output logic                     o_result_valid,
    input  wire logic                i_result_ready,
    output aifp_pkg::t_out_item      o_result,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [7:0]          i_cfg_data
);

    localparam int CW = $bits(aifp_pkg::t_class);
    localparam int RW = $bits(aifp_pkg::t_out_item);

    aifp_pkg::t_cfg      r_cfg;
    aifp_pkg::t_class    front_class;
    aifp_pkg::t_class    back_item;
    aifp_pkg::t_back_ctl back_ctl;
    aifp_pkg::t_out_item back_result;

    logic          in_full;
    logic          in_empty;
    logic [CW-1:0] in_rdata;
    logic          out_full;
    logic          out_empty;
    logic [RW-1:0] out_rdata;

    assign o_cfg_ready    = 1'b1;
    assign o_item_ready   = !in_full;
    assign o_result_valid = !out_empty;
    assign o_result       = aifp_pkg::t_out_item'(out_rdata);
    assign back_item      = aifp_pkg::t_class'(in_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aifp_pkg::REG_BASE_MODE:  r_cfg.base_mode  <= i_cfg_data[1:0];
                aifp_pkg::REG_MAX_DIGITS: r_cfg.max_digits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aifp_front u_front (
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .o_class (front_class)
    );

    aifp_queue #(
        .WIDTH      (CW),
        .DEPTH_LOG2 (2)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_item_valid),
        .i_wdata (front_class),
        .o_full  (in_full),
        .i_pop   (back_ctl.pop),
        .o_rdata (in_rdata),
        .o_empty (in_empty)
    );

    aifp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (!in_empty),
        .i_item       (back_item),
        .i_out_full   (out_full),
        .o_ctl        (back_ctl),
        .o_result     (back_result)
    );

    aifp_queue #(
        .WIDTH      (RW),
        .DEPTH_LOG2 (2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_ctl.push),
        .i_wdata (back_result),
        .o_full  (out_full),
        .i_pop   (i_result_ready),
        .o_rdata (out_rdata),
        .o_empty (out_empty)
    );

`ifndef SYNTHESIS
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctl.push |-> !out_full)
        else $error("result pushed into a full output queue");

    a_spill_blocks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctl.spill |-> !back_ctl.pop)
        else $error("new request taken while a second result is pending");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == aifp_pkg::ST_END
                            || o_result.status == aifp_pkg::ST_MISMATCH))
        |-> o_result.last_result)
        else $error("end or mismatch status not flagged as last result");
`endif

endmodule

`default_nettype wire

@@ tb/ascii_integer_field_parser_core_test.sv @@
// self-checking bench for ascii_integer_field_parser_core: text requests in, converted fields out
// depends on aifp_pkg and the core; a scanf-style conversion model predicts every result
`timescale 1ns / 100ps

module ascii_integer_field_parser_core_test;

    import aifp_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] BASE_DEC    = 2'd0;
    localparam logic [1:0] BASE_UNUSED = 2'd3;
    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         SETTLE_CYCLES = 20;

    typedef enum logic [2:0] {
        SCAN_WS, SCAN_SIGN, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS
    } t_scan;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_item_valid = 1'b0;
    logic       o_item_ready;
    t_in_item   i_item = '0;
    logic       o_result_valid;
    logic       i_result_ready = 1'b0;
    t_out_item  o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    // conversion model state
    logic [1:0]  conv_base = '0;
    logic [7:0]  conv_max_digits = '0;
    t_scan       conv_scan = SCAN_WS;
    logic [31:0] conv_accum = '0;
    logic [7:0]  conv_ndigits = '0;
    logic        conv_negative = 1'b0;
    logic        conv_halted = 1'b0;
    t_out_item   queued_conversions[$];

    int error_count = 0;
    int live_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int result_hold = 0;

    ascii_integer_field_parser_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_item_valid),
        .o_item_ready   (o_item_ready),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int radix();
        if (conv_base == BASE_HEX) return 16;
        if (conv_base == BASE_OCT) return 8;
        return 10;
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic int digit_value(input logic [7:0] b);
        int d;
        if (b >= CH_0 && b <= CH_9) begin
            d = int'(b - CH_0);
            return (d < radix()) ? d : -1;
        end
        if (radix() == 16 && b >= CH_A_LO && b <= CH_F_LO) return b - CH_A_LO + 10;
        if (radix() == 16 && b >= CH_A_UP && b <= CH_F_UP) return b - CH_A_UP + 10;
        return -1;
    endfunction

    function automatic void push_conversion(input logic [31:0] value, input logic [1:0] st);
        t_out_item r;
        r.field_value = value;
        r.status = st;
        r.last_result = 1'b0;
        queued_conversions.push_back(r);
    endfunction

    function automatic void clear_field();
        conv_scan = SCAN_WS;
        conv_accum = '0;
        conv_ndigits = '0;
        conv_negative = 1'b0;
    endfunction

    function automatic void close_field();
        push_conversion(conv_negative ? 32'd0 - conv_accum : conv_accum, ST_FIELD);
        clear_field();
    endfunction

    function automatic void flag_mismatch();
        push_conversion('0, ST_MISMATCH);
        clear_field();
        conv_halted = 1'b1;
    endfunction

    function automatic void take_digit(input int d);
        conv_accum = conv_accum * radix() + d;
        if (conv_ndigits != 8'd255) conv_ndigits++;
        conv_scan = SCAN_DIGITS;
        if (conv_max_digits != 0 && conv_ndigits >= conv_max_digits) close_field();
    endfunction

    function automatic void start_field(input logic [7:0] b);
        int d;
        d = digit_value(b);
        if (is_space(b)) return;
        if (radix() == 10 && (b == CH_MINUS || b == CH_PLUS)) begin
            clear_field();
            conv_negative = (b == CH_MINUS);
            conv_scan = SCAN_SIGN;
            return;
        end
        if (radix() == 16 && b == CH_0) begin
            clear_field();
            conv_scan = SCAN_ZERO;
            return;
        end
        if (d >= 0) begin
            clear_field();
            take_digit(d);
            return;
        end
        flag_mismatch();
    endfunction

    // a byte that does not belong to the field closes it and is scanned again
    function automatic void continue_field(input logic [7:0] b);
        int d;
        d = digit_value(b);
        if (d >= 0) begin
            take_digit(d);
        end else begin
            close_field();
            start_field(b);
        end
    endfunction

    function automatic void convert_item(input logic [1:0] cmd, input logic [7:0] b);
        int first;
        int d;
        t_out_item r;
        first = queued_conversions.size();
        if (cmd == CMD_RESTART) begin
            clear_field();
            conv_halted = 1'b0;
            return;
        end
        if (cmd == CMD_UNUSED || conv_halted) return;
        if (cmd == CMD_TEXT) begin
            case (conv_scan)
                SCAN_SIGN, SCAN_PREFIX: begin
                    d = digit_value(b);
                    if (d >= 0) take_digit(d);
                    else flag_mismatch();
                end
                SCAN_ZERO: begin
                    if (b == CH_X_LO || b == CH_X_UP) begin
                        conv_scan = SCAN_PREFIX;
                    end else begin
                        take_digit(0);
                        if (conv_scan == SCAN_WS) start_field(b);
                        else continue_field(b);
                    end
                end
                SCAN_DIGITS: continue_field(b);
                default: start_field(b);
            endcase
        end else begin
            // a lone sign or 0x prefix is dropped at end of text
            if (conv_scan == SCAN_DIGITS || conv_scan == SCAN_ZERO) close_field();
            clear_field();
            push_conversion('0, ST_END);
            conv_halted = 1'b1;
        end
        if (queued_conversions.size() > first) begin
            r = queued_conversions.pop_back();
            r.last_result = 1'b1;
            queued_conversions.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 100) $display("%0t ns: %s", $time, what);
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_item_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_item_valid <= 1'b1;
        i_item.command <= cmd;
        i_item.text_byte <= b;
        do @(posedge i_clk); while (!o_item_ready);
        if ((!conv_halted && cmd != CMD_UNUSED) || cmd == CMD_RESTART) live_count++;
        convert_item(cmd, b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(CMD_TEXT, s[i]);
    endtask

    // stop sending, let every predicted result come out, then let the core settle
    task automatic drain_conversions();
        i_item_valid <= 1'b0;
        while (queued_conversions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_index, input logic [7:0] data);
        drain_conversions();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (reg_index == REG_BASE_MODE) conv_base = data[1:0];
        else if (reg_index == REG_MAX_DIGITS) conv_max_digits = data;
    endtask

    function automatic logic [7:0] digit_char();
        int d;
        d = $urandom_range(radix() - 1);
        if (d < 10) return 8'(CH_0 + d);
        return 8'(($urandom_range(1) ? CH_A_LO : CH_A_UP) + d - 10);
    endfunction

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    // one token of random text: mostly a well-formed field in the current base
    task automatic send_random_token();
        int r;
        int len;
        r = $urandom_range(99);
        if (conv_halted) begin
            if (r < 80) send_item(CMD_RESTART, 8'($urandom_range(255)));
            else send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if (r < 70) begin
            repeat ($urandom_range(2)) send_item(CMD_TEXT, space_char());
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
            r = $urandom_range(5);
            if (radix() == 10 && r == 0) send_item(CMD_TEXT, CH_MINUS);
            if (radix() == 10 && r == 1) send_item(CMD_TEXT, CH_PLUS);
            if (radix() == 16 && r == 0) begin
                send_item(CMD_TEXT, CH_0);
                len = 0;
            end
            if (radix() == 16 && (r == 1 || r == 2)) begin
                send_item(CMD_TEXT, CH_0);
                send_item(CMD_TEXT, r == 1 ? CH_X_LO : CH_X_UP);
            end
            repeat (len) send_item(CMD_TEXT, digit_char());
            if ($urandom_range(9) < 7) send_item(CMD_TEXT, space_char());
        end else if (r < 78) begin
            send_item(CMD_END, 8'($urandom_range(255)));
        end else if (r < 83) begin
            send_item(CMD_RESTART, 8'($urandom_range(255)));
        end else if (r < 86) begin
            send_item(CMD_UNUSED, 8'($urandom_range(255)));
        end else begin
            send_item(CMD_TEXT, 8'($urandom_range(255)));
        end
    endtask

    task automatic write_random_config();
        int r;
        r = $urandom_range(9);
        write_reg(REG_BASE_MODE, 8'($urandom_range(3)));
        if (r < 4) write_reg(REG_MAX_DIGITS, 8'd0);
        else if (r == 4) write_reg(REG_MAX_DIGITS, 8'd255);
        else if (r == 5) write_reg(REG_MAX_DIGITS, 8'd1);
        else if (r == 6) write_reg(REG_MAX_DIGITS, 8'($urandom_range(255)));
        else write_reg(REG_MAX_DIGITS, 8'($urandom_range(2, 8)));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_decimal_fields();
        send_text("-12+3x");            // a sign closes a field; x closes one and mismatches
        send_item(CMD_TEXT, CH_0 + 8'd5);  // ignored while halted
        send_item(CMD_RESTART, 8'hFF);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_RESTART, 8'h00);
    endtask

    task automatic test_hex_and_limit();
        write_reg(REG_BASE_MODE, 8'(BASE_HEX));
        send_text("0xfF ");
        send_text("0XE");
        // digit limit changed in the middle of a field
        write_reg(REG_MAX_DIGITS, 8'd2);
        send_text("A0");
        send_item(CMD_END, 8'h55);      // lone zero then end
        send_item(CMD_RESTART, 8'hAA);
    endtask

    task automatic test_octal_and_unused();
        write_reg(REG_BASE_MODE, 8'(BASE_OCT));
        write_reg(REG_MAX_DIGITS, 8'd0);
        send_text("78");
        send_item(CMD_UNUSED, 8'hFF);
        send_item(CMD_RESTART, 8'h00);
        write_reg(REG_SPARE, 8'($urandom_range(255)));
        write_reg(REG_BASE_MODE, 8'(BASE_UNUSED));
        write_reg(REG_MAX_DIGITS, 8'd255);
        send_text("-1");
        send_item(CMD_END, 8'h00);
        send_item(CMD_RESTART, 8'hFF);
    endtask

    // results held back long enough that both queues fill and the input stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_BASE_MODE, 8'(BASE_HEX));
        write_reg(REG_MAX_DIGITS, 8'd1);
        send_item(CMD_RESTART, 8'h00);
        i_item_valid <= 1'b0;
        @(negedge i_clk);
        result_hold = 300;
        @(posedge i_clk);
        repeat (40) send_item(CMD_TEXT, CH_A_UP + 8'($urandom_range(5)));
        drain_conversions();
    endtask

    task automatic test_random_text(input int send_pct, input int recv_pct, input int items);
        int target;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = live_count + items;
        while (live_count < target) begin
            if ($urandom_range(24) == 0) write_random_config();
            send_random_token();
        end
    endtask

    // ---------------------------------------------------------------- receiver and checker

    always @(posedge i_clk) begin
        if (result_hold > 0) begin
            result_hold = result_hold - 1;
            i_result_ready <= 1'b0;
        end else begin
            i_result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_conversions
        t_out_item want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (queued_conversions.size() == 0) begin
                report_mismatch($sformatf("result with none pending: %h", o_result));
            end else begin
                want = queued_conversions.pop_front();
                if (o_result.field_value !== want.field_value)
                    report_mismatch($sformatf("field_value %h, model %h",
                                              o_result.field_value, want.field_value));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, model %0d",
                                              o_result.status, want.status));
                if (o_result.last_result !== want.last_result)
                    report_mismatch($sformatf("last_result %b, model %b",
                                              o_result.last_result, want.last_result));
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_decimal_fields();
        test_hex_and_limit();
        test_octal_and_unused();
        test_output_backpressure();
        write_reg(REG_BASE_MODE, 8'(BASE_DEC));
        write_reg(REG_MAX_DIGITS, 8'd0);
        test_random_text(0, 0, 300);
        test_random_text(75, 0, 300);
        test_random_text(0, 75, 300);
        test_random_text(10, 10, 300);
        drain_conversions();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/aifp_pkg.sv
hdl/aifp_queue.sv
hdl/aifp_front.sv
hdl/aifp_back.sv
hdl/ascii_integer_field_parser_core.sv
tb/ascii_integer_field_parser_core_test.sv
